/* rtl/ita2enc_pkg.sv */
// ----------------------------------------------------------------------------
// ita2enc_pkg
// Types, code constants, character tables and state update helpers for the
// ASCII to ITA2 encoder.
// ----------------------------------------------------------------------------
package ita2enc_pkg;

   typedef logic [4:0] code_type;
   typedef logic [7:0] char_type;
   typedef logic [1:0] shift_type;
   typedef logic [1:0] class_type;
   typedef logic [2:0] level_type;

   localparam code_type CODE_NULL = 5'h00;
   localparam code_type CODE_LF   = 5'h02;
   localparam code_type CODE_CR   = 5'h08;
   localparam code_type CODE_BELL = 5'h0b;
   localparam code_type CODE_PLUS = 5'h11;
   localparam code_type CODE_FIGS = 5'h1b;
   localparam code_type CODE_LTRS = 5'h1f;

   localparam shift_type SHIFT_NONE = 2'd0;
   localparam shift_type SHIFT_LTRS = 2'd1;
   localparam shift_type SHIFT_FIGS = 2'd2;

   // which table(s) hold the character
   localparam class_type CLASS_LTRS = 2'd1;
   localparam class_type CLASS_FIGS = 2'd2;
   localparam class_type CLASS_BOTH = 2'd3;

   localparam logic CSR_FILTER_LEVEL = 1'b0;
   localparam logic CSR_LINE_WIDTH   = 1'b1;

   localparam level_type FILTER_RESET = 3'd0;
   localparam char_type  WIDTH_RESET  = 8'd69;
   localparam char_type  COLUMN_MAX   = 8'hff;

   localparam int TAB_DEPTH = 32;

   typedef struct packed {
      code_type  code;
      class_type cls;
   } entry_type;

   localparam char_type LETTERS_TAB [TAB_DEPTH] = '{
      8'h2a, 8'h65, 8'h0a, 8'h61, 8'h20, 8'h73, 8'h69, 8'h75,
      8'h0d, 8'h64, 8'h72, 8'h6a, 8'h6e, 8'h66, 8'h63, 8'h6b,
      8'h74, 8'h7a, 8'h6c, 8'h77, 8'h68, 8'h79, 8'h70, 8'h71,
      8'h6f, 8'h62, 8'h67, 8'h7e, 8'h6d, 8'h78, 8'h76, 8'h5e};

   localparam char_type FIGURES_TAB [TAB_DEPTH] = '{
      8'h2a, 8'h33, 8'h0a, 8'h2d, 8'h20, 8'h27, 8'h38, 8'h37,
      8'h0d, 8'h24, 8'h34, 8'h25, 8'h2c, 8'h21, 8'h3a, 8'h28,
      8'h35, 8'h2b, 8'h29, 8'h32, 8'h23, 8'h36, 8'h30, 8'h31,
      8'h39, 8'h3f, 8'h26, 8'h7e, 8'h2e, 8'h2f, 8'h3d, 8'h5e};

   function automatic logic is_printing(input code_type code);
      is_printing = !(code == CODE_CR || code == CODE_LF || code == CODE_BELL ||
                      code == CODE_NULL || code == CODE_LTRS || code == CODE_FIGS);
   endfunction

   function automatic shift_type next_shift(input code_type code, input shift_type sh);
      shift_type r;
      r = sh;
      if (code == CODE_LTRS) begin
         r = SHIFT_LTRS;
      end else if (code == CODE_FIGS) begin
         r = SHIFT_FIGS;
      end
      next_shift = r;
   endfunction

   function automatic char_type next_column(input code_type code, input shift_type sh,
                                            input char_type col);
      char_type r;
      r = col;
      priority if (code == CODE_LF || code == CODE_NULL ||
                   code == CODE_LTRS || code == CODE_FIGS) begin
         r = col;
      end else if (code == CODE_CR) begin
         r = 8'd0;
      end else if (code == CODE_BELL) begin
         if (sh == SHIFT_LTRS && col != COLUMN_MAX) begin
            r = col + 8'd1;
         end
      end else begin
         if (col != COLUMN_MAX) begin
            r = col + 8'd1;
         end
      end
      next_column = r;
   endfunction

endpackage

/* rtl/ita2enc_front.sv */
// ----------------------------------------------------------------------------
// ita2enc_front
// Filters, folds and classifies one input character into its ITA2 code and
// the table(s) that hold it.
// ----------------------------------------------------------------------------
module ita2enc_front
   import ita2enc_pkg::*;
(
   input  level_type filter_level,
   input  char_type  ascii_char,
   output entry_type entry,
   output logic      drop
);

   char_type  c;
   logic      hit_l;
   logic      hit_f;
   code_type  idx_l;
   code_type  idx_f;

   always_comb begin
      c = ascii_char;
      if (filter_level >= 3'd1 && filter_level <= 3'd4) begin
         if (filter_level >= 3'd4 && (c == 8'h21 || c == 8'h23 || c == 8'h26)) begin
            c = 8'h2b;
         end
         if (filter_level >= 3'd3 && c == 8'h25) begin
            c = 8'h2b;
         end
         if (filter_level >= 3'd2 && c == 8'h2a) begin
            c = 8'h2b;
         end
         if (c == 8'h7e || c == 8'h5e || c == 8'h24) begin
            c = 8'h2b;
         end
      end
      // upper to lower case, quote marks to apostrophe
      if (c >= 8'h41 && c <= 8'h5a) begin
         c = c + 8'h20;
      end
      if (c == 8'h22 || c == 8'h60) begin
         c = 8'h27;
      end

      hit_l = 1'b0;
      hit_f = 1'b0;
      idx_l = CODE_NULL;
      idx_f = CODE_NULL;
      for (int i = 0; i < TAB_DEPTH; i++) begin
         if (LETTERS_TAB[i] == c) begin
            hit_l = 1'b1;
            idx_l = code_type'(i);
         end
         if (FIGURES_TAB[i] == c) begin
            hit_f = 1'b1;
            idx_f = code_type'(i);
         end
      end

      if (hit_l && hit_f) begin
         entry.code = idx_l;
         entry.cls  = CLASS_BOTH;
      end else if (hit_l) begin
         entry.code = idx_l;
         entry.cls  = CLASS_LTRS;
      end else if (hit_f) begin
         entry.code = idx_f;
         entry.cls  = CLASS_FIGS;
      end else begin
         entry.code = CODE_PLUS;
         entry.cls  = CLASS_FIGS;
      end

      // carriage return input sends nothing
      drop = (entry.code == CODE_CR);
   end

endmodule

/* rtl/ita2enc_queue.sv */
// ----------------------------------------------------------------------------
// ita2enc_queue
// Short first-in first-out queue of classified characters between the front
// and back parts.
// ----------------------------------------------------------------------------
module ita2enc_queue
   import ita2enc_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  entry_type wr_entry,
   output logic      full,
   output logic      rd_valid,
   output entry_type rd_entry,
   input  logic      rd_en
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      rd_valid  = (count_ff != '0);
      rd_entry  = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_en ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/ita2enc_back.sv */
// ----------------------------------------------------------------------------
// ita2enc_back
// Sequencer that expands one classified character into its CR LF, null, shift
// and character codes, tracks shift and column, and holds the result register.
// ----------------------------------------------------------------------------
module ita2enc_back
   import ita2enc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  char_type  line_width,
   input  logic      q_valid,
   input  entry_type q_entry,
   output logic      q_pop,
   input  logic      pop,
   output logic      empty,
   output code_type  ita2_code,
   output logic      last
);

   // step bits: 0 cr, 1 lf, 2 null, 3 shift, 4 shift, 5 character
   logic [5:0] rem_ff, rem_in;
   code_type   code_ff, code_in;
   code_type   sc_ff, sc_in;
   shift_type  shift_ff, shift_in;
   char_type   col_ff, col_in;
   logic       out_valid_ff, out_valid_in;
   code_type   out_code_ff, out_code_in;
   logic       out_last_ff, out_last_in;

   logic [5:0] low;
   logic [5:0] plan;
   logic       busy;
   logic       is_last;
   logic       can_emit;
   logic       fire;
   logic       load;
   logic       crlf;
   logic       shf;
   code_type   step_code;
   shift_type  sh_use;
   char_type   col_use;
   shift_type  table_sel;

   always_comb begin
      low     = rem_ff & (~rem_ff + 6'd1);
      busy    = (rem_ff != 6'd0);
      is_last = ((rem_ff & (rem_ff - 6'd1)) == 6'd0);

      priority if (low[0]) begin
         step_code = CODE_CR;
      end else if (low[1]) begin
         step_code = CODE_LF;
      end else if (low[2]) begin
         step_code = CODE_NULL;
      end else if (low[3] || low[4]) begin
         step_code = sc_ff;
      end else begin
         step_code = code_ff;
      end

      can_emit = !out_valid_ff || pop;
      fire     = busy && can_emit;
      sh_use   = fire ? next_shift(step_code, shift_ff) : shift_ff;
      col_use  = fire ? next_column(step_code, shift_ff, col_ff) : col_ff;

      load  = q_valid && (!busy || (fire && is_last));
      q_pop = load;

      // plan for the next transaction from the state after this cycle's code
      if (q_entry.cls == CLASS_BOTH) begin
         table_sel = (sh_use == SHIFT_LTRS) ? SHIFT_LTRS : SHIFT_FIGS;
      end else if (q_entry.cls == CLASS_LTRS) begin
         table_sel = SHIFT_LTRS;
      end else begin
         table_sel = SHIFT_FIGS;
      end
      crlf = is_printing(q_entry.code) && (col_use >= line_width);
      shf  = (table_sel != sh_use);
      if (q_entry.code == CODE_LF) begin
         plan = 6'b000011;
      end else begin
         plan = {1'b1, shf, shf, shf, crlf, crlf};
      end

      if (load) begin
         rem_in  = plan;
         code_in = q_entry.code;
         sc_in   = (table_sel == SHIFT_LTRS) ? CODE_LTRS : CODE_FIGS;
      end else begin
         rem_in  = fire ? (rem_ff & ~low) : rem_ff;
         code_in = code_ff;
         sc_in   = sc_ff;
      end
      shift_in = sh_use;
      col_in   = col_use;

      if (can_emit) begin
         out_valid_in = fire;
         out_code_in  = step_code;
         out_last_in  = is_last;
      end else begin
         out_valid_in = out_valid_ff;
         out_code_in  = out_code_ff;
         out_last_in  = out_last_ff;
      end

      empty     = !out_valid_ff;
      ita2_code = out_code_ff;
      last      = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= 6'd0;
         shift_ff     <= SHIFT_NONE;
         col_ff       <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         shift_ff     <= shift_in;
         col_ff       <= col_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      sc_ff       <= sc_in;
      out_code_ff <= out_code_in;
      out_last_ff <= out_last_in;
   end

endmodule

/* rtl/ascii_to_ita2_encoder_unit.sv */
// ----------------------------------------------------------------------------
// ascii_to_ita2_encoder_unit
// Turns ASCII characters into ITA2 five-bit codes with automatic CR LF,
// shift sequences and a character filter.
// ----------------------------------------------------------------------------
// usage:
//   input queue: drive req_ascii_char with push while full is low; the
//   character is taken at that edge. a carriage return is taken and dropped.
//   output queue: while empty is low the oldest code is on rsp_ita2_code,
//   rsp_last marks the final code of a character; pop takes it.
//   csr port: write filter_level (index 0) or line_width (index 1) with
//   csr_wen while nothing is in flight.
// timing:
//   a taken character passes through the queue and the sequencer step
//   register before its first code reaches the result register; codes then
//   follow one per cycle while pop is high, and a character expands to 1
//   to 6 codes. the front takes one character per cycle while full is low
//   into a queue of QUEUE_DEPTH entries, so input keeps flowing while codes drain.
// reset: clears the queue, the result register, shift (unknown), column
//   (0), filter level (0) and line width (69).
// stall: with pop low a code in the result register holds and the sequencer
//   waits; full rises once the queue is filled.
// ----------------------------------------------------------------------------
module ascii_to_ita2_encoder_unit
   import ita2enc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_ascii_char,
   output logic       empty,
   input  logic       pop,
   output logic [4:0] rsp_ita2_code,
   output logic       rsp_last,
   input  logic       csr_wen,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   level_type filter_level_ff, filter_level_in;
   char_type  line_width_ff, line_width_in;

   entry_type front_entry;
   logic      front_drop;
   logic      q_wr;
   logic      q_valid;
   entry_type q_entry;
   logic      q_pop;

   always_comb begin
      filter_level_in = filter_level_ff;
      line_width_in   = line_width_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_FILTER_LEVEL: filter_level_in = csr_wdata[2:0];
            CSR_LINE_WIDTH:   line_width_in   = csr_wdata;
            default: begin
               filter_level_in = filter_level_ff;
            end
         endcase
      end
      // transaction accepted; dropped ones never enter the queue
      q_wr = push && !full && !front_drop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_level_ff <= FILTER_RESET;
         line_width_ff   <= WIDTH_RESET;
      end else begin
         filter_level_ff <= filter_level_in;
         line_width_ff   <= line_width_in;
      end
   end

   ita2enc_front u_front (
      .filter_level (filter_level_ff),
      .ascii_char   (req_ascii_char),
      .entry        (front_entry),
      .drop         (front_drop)
   );

   ita2enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr),
      .wr_entry (front_entry),
      .full     (full),
      .rd_valid (q_valid),
      .rd_entry (q_entry),
      .rd_en    (q_pop)
   );

   ita2enc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .line_width (line_width_ff),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .pop        (pop),
      .empty      (empty),
      .ita2_code  (rsp_ita2_code),
      .last       (rsp_last)
   );

endmodule

/* verif/ascii_to_ita2_encoder_unit_test.sv */
// ----------------------------------------------------------------------------
// ascii_to_ita2_encoder_unit_test
// Self-checking bench for the ASCII to ITA2 encoder. Characters go in through
// the push side with random gaps. A tracking model of shift, column, filter
// level and line width predicts the codes of each character. Every popped code
// is compared with the oldest prediction. Covered: directed edge characters,
// every filter level, narrow and saturating line widths, a long receiver
// hold-off that backs up the input, and random traffic under changing settings.
// ----------------------------------------------------------------------------
module ascii_to_ita2_encoder_unit_test;
   import ita2enc_pkg::*;

   localparam int SETTLE_CYCLES   = 32;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int STUCK_LIMIT     = 2000;

   typedef struct packed {
      code_type code;
      logic     last;
   } ita2_result_type;

   localparam char_type LTRS_CHARS [32] = '{
      "*", "e", 8'h0a, "a", " ", "s", "i", "u", 8'h0d, "d", "r", "j", "n", "f", "c", "k",
      "t", "z", "l", "w", "h", "y", "p", "q", "o", "b", "g", "~", "m", "x", "v", "^"};
   localparam char_type FIGS_CHARS [32] = '{
      "*", "3", 8'h0a, "-", " ", "'", "8", "7", 8'h0d, "$", "4", "%", ",", "!", ":", "(",
      "5", "+", ")", "2", "#", "6", "0", "1", "9", "?", "&", "~", ".", "/", "=", "^"};
   localparam char_type FILTERED_CHARS [9] = '{
      "~", "^", "$", "*", "%", "!", "#", "&", "+"};
   localparam char_type EDGE_CHARS [25] = '{
      8'h00, 8'hff, 8'h80, 8'h7f, "A", "Z", "a", "z", 8'h22, 8'h60, 8'h0d, 8'h0a,
      "~", "a", "~", "^", "$", "*", "%", "!", "#", "&", "0", " ", "j"};

   logic     clock = 1'b0;
   logic     reset;
   logic     push;
   logic     full;
   char_type req_ascii_char;
   logic     empty;
   logic     pop = 1'b0;
   code_type rsp_ita2_code;
   logic     rsp_last;
   logic     csr_wen;
   logic     csr_index;
   char_type csr_wdata;

   level_type model_filter;
   char_type  model_width;
   shift_type model_shift;
   char_type  model_column;

   ita2_result_type code_burst[$];
   ita2_result_type codes_due[$];
   ita2_result_type popped;

   int  fail_count = 0;
   int  stuck_cycles = 0;
   bit  idle_en = 1'b1;
   bit  rsp_hold_req = 1'b0;
   int  rsp_stall = 0;

   ascii_to_ita2_encoder_unit dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_ascii_char  (req_ascii_char),
      .empty           (empty),
      .pop             (pop),
      .rsp_ita2_code   (rsp_ita2_code),
      .rsp_last        (rsp_last),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(15, 60);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic int table_index(input bit figs, input char_type ch);
      for (int i = 0; i < 32; i++) begin
         if ((figs ? FIGS_CHARS[i] : LTRS_CHARS[i]) == ch) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic bit glyph_prints(input code_type c);
      return !(c == CODE_CR || c == CODE_LF || c == CODE_BELL || c == CODE_NULL ||
               c == CODE_LTRS || c == CODE_FIGS);
   endfunction

   // one code on the line, with its effect on shift and column
   function automatic void line_code(input code_type c);
      ita2_result_type r;
      r.code = c;
      r.last = 1'b0;
      code_burst.push_back(r);
      if (c == CODE_LTRS) begin
         model_shift = SHIFT_LTRS;
      end else if (c == CODE_FIGS) begin
         model_shift = SHIFT_FIGS;
      end else if (c == CODE_CR) begin
         model_column = 8'd0;
      end else if (c == CODE_BELL) begin
         if (model_shift == SHIFT_LTRS && model_column != COLUMN_MAX) begin
            model_column = model_column + 8'd1;
         end
      end else if (c != CODE_LF && c != CODE_NULL) begin
         if (model_column != COLUMN_MAX) begin
            model_column = model_column + 8'd1;
         end
      end
   endfunction

   function automatic void encode_char(input char_type raw);
      char_type        ch;
      int              il;
      int              ifg;
      shift_type       want;
      code_type        code;
      code_type        shift_code;
      ita2_result_type r;
      ch = raw;
      if (model_filter >= 3'd1 && model_filter <= 3'd4) begin
         if (model_filter >= 3'd4 && (ch == "!" || ch == "#" || ch == "&")) begin
            ch = "+";
         end
         if (model_filter >= 3'd3 && ch == "%") begin
            ch = "+";
         end
         if (model_filter >= 3'd2 && ch == "*") begin
            ch = "+";
         end
         if (ch == "~" || ch == "^" || ch == "$") begin
            ch = "+";
         end
      end
      if (ch >= "A" && ch <= "Z") begin
         ch = ch + 8'd32;
      end
      if (ch == 8'h22 || ch == 8'h60) begin
         ch = "'";
      end
      il  = table_index(1'b0, ch);
      ifg = table_index(1'b1, ch);
      if (il >= 0 && ifg >= 0) begin
         if (model_shift == SHIFT_LTRS) begin
            want = SHIFT_LTRS;
            code = il[4:0];
         end else begin
            want = SHIFT_FIGS;
            code = ifg[4:0];
         end
      end else if (il >= 0) begin
         want = SHIFT_LTRS;
         code = il[4:0];
      end else if (ifg >= 0) begin
         want = SHIFT_FIGS;
         code = ifg[4:0];
      end else begin
         want = SHIFT_FIGS;
         code = CODE_PLUS;
      end
      code_burst.delete();
      if (code == CODE_CR) begin
         return;
      end
      if (code == CODE_LF) begin
         line_code(CODE_CR);
         line_code(CODE_LF);
      end else begin
         if (glyph_prints(code) && model_column >= model_width) begin
            line_code(CODE_CR);
            line_code(CODE_LF);
         end
         if (want != model_shift) begin
            shift_code = (want == SHIFT_LTRS) ? CODE_LTRS : CODE_FIGS;
            line_code(CODE_NULL);
            line_code(shift_code);
            line_code(shift_code);
            model_shift = want;
         end
         line_code(code);
      end
      for (int i = 0; i < code_burst.size(); i++) begin
         r = code_burst[i];
         r.last = (i == code_burst.size() - 1);
         codes_due.push_back(r);
      end
   endfunction

   function automatic char_type random_char();
      int       pick;
      char_type ch;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         ch = LTRS_CHARS[$urandom_range(0, 31)];
         if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) begin
            ch = ch - 8'd32;
         end
      end else if (pick < 65) begin
         ch = FIGS_CHARS[$urandom_range(0, 31)];
      end else if (pick < 72) begin
         ch = 8'h0a;
      end else if (pick < 76) begin
         ch = 8'h0d;
      end else if (pick < 84) begin
         ch = FILTERED_CHARS[$urandom_range(0, 8)];
      end else begin
         ch = char_type'($urandom_range(0, 255));
      end
      return ch;
   endfunction

   task automatic send_char(input char_type ch);
      int gap;
      @(negedge clock);
      push           <= 1'b1;
      req_ascii_char <= ch;
      @(posedge clock);
      while (full) @(posedge clock);
      encode_char(ch);
      if (idle_en && $urandom_range(0, 2) == 0) begin
         gap = gap_length();
         @(negedge clock);
         push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_codes();
      @(negedge clock);
      push <= 1'b0;
      while (codes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input char_type value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_FILTER_LEVEL) begin
         model_filter = value[2:0];
      end else begin
         model_width = value;
      end
   endtask

   task automatic test_edge_chars();
      for (int i = 0; i < 25; i++) begin
         send_char(EDGE_CHARS[i]);
      end
      drain_codes();
   endtask

   task automatic test_filter_levels();
      for (int lvl = 0; lvl < 8; lvl++) begin
         write_csr(CSR_FILTER_LEVEL, char_type'(lvl));
         send_char(random_char());
         for (int i = 0; i < 9; i++) begin
            send_char(FILTERED_CHARS[i]);
         end
         drain_codes();
      end
   endtask

   task automatic test_line_widths();
      char_type widths [3];
      widths = '{8'd0, 8'd1, 8'd7};
      write_csr(CSR_FILTER_LEVEL, char_type'(0));
      for (int w = 0; w < 3; w++) begin
         write_csr(CSR_LINE_WIDTH, widths[w]);
         for (int i = 0; i < 15; i++) begin
            send_char(random_char());
         end
         drain_codes();
      end
   endtask

   // letters-shift bell advances the column without a forced new line
   task automatic test_column_saturation();
      write_csr(CSR_LINE_WIDTH, 8'd255);
      send_char(8'h0a);
      for (int i = 0; i < 258; i++) begin
         send_char(($urandom_range(0, 1) == 1) ? "j" : "J");
      end
      send_char("a");
      send_char("5");
      send_char("j");
      drain_codes();
   endtask

   task automatic test_backpressure();
      write_csr(CSR_FILTER_LEVEL, char_type'($urandom_range(0, 7)));
      write_csr(CSR_LINE_WIDTH, char_type'($urandom_range(1, 20)));
      idle_en      = 1'b0;
      rsp_hold_req = 1'b1;
      for (int i = 0; i < 24; i++) begin
         send_char(random_char());
      end
      drain_codes();
      idle_en = 1'b1;
   endtask

   task automatic test_random_traffic();
      int       pick;
      char_type width;
      for (int phase = 0; phase < 4; phase++) begin
         pick = $urandom_range(0, 3);
         case (pick)
            0:       width = 8'd1;
            1:       width = char_type'($urandom_range(2, 20));
            2:       width = char_type'($urandom_range(21, 255));
            default: width = 8'd69;
         endcase
         write_csr(CSR_FILTER_LEVEL, char_type'($urandom_range(0, 7)));
         write_csr(CSR_LINE_WIDTH, width);
         idle_en = (phase != 1);
         for (int i = 0; i < 8; i++) begin
            send_char(random_char());
         end
         drain_codes();
      end
      idle_en = 1'b1;
   endtask

   // receiver side: random stalls plus the long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_stall    = RSP_HOLD_CYCLES;
         end else if (rsp_stall == 0 && idle_en && $urandom_range(0, 3) == 0) begin
            rsp_stall = gap_length();
         end
         if (rsp_stall > 0) begin
            pop <= 1'b0;
            rsp_stall--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (codes_due.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected transaction code %h last %b", $time,
                     rsp_ita2_code, rsp_last);
         end else begin
            popped = codes_due.pop_front();
            if (rsp_ita2_code !== popped.code) begin
               fail_count++;
               $display("%0t: ita2_code expected %h actual %h", $time,
                        popped.code, rsp_ita2_code);
            end
            if (rsp_last !== popped.last) begin
               fail_count++;
               $display("%0t: last expected %b actual %b", $time, popped.last, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      push           = 1'b0;
      req_ascii_char = 8'h00;
      csr_wen        = 1'b0;
      csr_index      = CSR_FILTER_LEVEL;
      csr_wdata      = 8'h00;
      model_filter   = 3'd0;
      model_width    = 8'd69;
      model_shift    = SHIFT_NONE;
      model_column   = 8'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_chars();
      test_filter_levels();
      test_line_widths();
      test_column_saturation();
      test_backpressure();
      test_random_traffic();

      if (codes_due.size() != 0) begin
         fail_count++;
         $display("%0t: %0d codes never arrived", $time, codes_due.size());
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
